// ===== sv/sle_pkg.sv =====
package sle_pkg;

    localparam int LEN_W      = 5;
    localparam int CHAR_W     = 7;
    localparam int SCAN_W     = 8;
    localparam int PERIOD_W   = 8;
    localparam int TEXT_CHARS = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 2'd1;

    localparam logic [LEN_W-1:0]    CHAR_LIMIT_RESET   = 5'd16;
    localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RESET = 8'd72;

    // Command codes
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Set-1 make codes with a special meaning
    localparam logic [SCAN_W-1:0] SC_ENTER     = 8'h1C;
    localparam logic [SCAN_W-1:0] SC_LEFT      = 8'h4B;
    localparam logic [SCAN_W-1:0] SC_RIGHT     = 8'h4D;
    localparam logic [SCAN_W-1:0] SC_BACKSPACE = 8'h0E;

    typedef struct packed {
        logic              command;
        logic [SCAN_W-1:0] scancode;
        logic              focused;
    } sle_item_t;

    typedef struct packed {
        logic [63:0]      text_low;
        logic [63:0]      text_high;
        logic [LEN_W-1:0] text_length;
        logic [LEN_W-1:0] cursor_position;
        logic             cursor_shown;
        logic             release_focus;
    } sle_result_t;

    // Printable set-1 codes to ASCII; zero means not printable
    function automatic logic [CHAR_W-1:0] key_to_ascii(input logic [SCAN_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            8'h02:   ch = 7'h31;
            8'h03:   ch = 7'h32;
            8'h04:   ch = 7'h33;
            8'h05:   ch = 7'h34;
            8'h06:   ch = 7'h35;
            8'h07:   ch = 7'h36;
            8'h08:   ch = 7'h37;
            8'h09:   ch = 7'h38;
            8'h0A:   ch = 7'h39;
            8'h0B:   ch = 7'h30;
            8'h0C:   ch = 7'h2D;
            8'h10:   ch = 7'h51;
            8'h11:   ch = 7'h57;
            8'h12:   ch = 7'h45;
            8'h13:   ch = 7'h52;
            8'h14:   ch = 7'h54;
            8'h15:   ch = 7'h59;
            8'h16:   ch = 7'h55;
            8'h17:   ch = 7'h49;
            8'h18:   ch = 7'h4F;
            8'h19:   ch = 7'h50;
            8'h1E:   ch = 7'h41;
            8'h1F:   ch = 7'h53;
            8'h20:   ch = 7'h44;
            8'h21:   ch = 7'h46;
            8'h22:   ch = 7'h47;
            8'h23:   ch = 7'h48;
            8'h24:   ch = 7'h4A;
            8'h25:   ch = 7'h4B;
            8'h26:   ch = 7'h4C;
            8'h2C:   ch = 7'h5A;
            8'h2D:   ch = 7'h58;
            8'h2E:   ch = 7'h43;
            8'h2F:   ch = 7'h56;
            8'h30:   ch = 7'h42;
            8'h31:   ch = 7'h4E;
            8'h32:   ch = 7'h4D;
            8'h33:   ch = 7'h2C;
            8'h34:   ch = 7'h2E;
            8'h39:   ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== sv/sle_edit.sv =====
module sle_edit #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  sle_pkg::sle_item_t               item,
    input  logic [sle_pkg::LEN_W-1:0]        char_limit,
    input  logic [sle_pkg::PERIOD_W-1:0]     blink_period,
    output sle_pkg::sle_result_t             result
);

    localparam logic [sle_pkg::LEN_W-1:0] DEPTH_L = sle_pkg::LEN_W'(BUFFER_DEPTH);

    logic [sle_pkg::CHAR_W-1:0]   store_reg  [BUFFER_DEPTH];
    logic [sle_pkg::CHAR_W-1:0]   store_next [BUFFER_DEPTH];
    logic [sle_pkg::CHAR_W-1:0]   up_src     [BUFFER_DEPTH];
    logic [sle_pkg::CHAR_W-1:0]   down_src   [BUFFER_DEPTH];
    logic [sle_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [sle_pkg::LEN_W-1:0]    cur_reg, cur_next;
    logic [sle_pkg::PERIOD_W-1:0] count_reg, count_next;
    logic                         vis_reg, vis_next;
    logic                         release_next;
    logic [sle_pkg::LEN_W-1:0]    limit;
    logic [sle_pkg::CHAR_W-1:0]   ch;
    logic [sle_pkg::PERIOD_W:0]   count_inc;
    logic [sle_pkg::TEXT_CHARS*8-1:0] text_all;

    // Neighbor taps for the tail shifts; zero enters at the ends
    for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_taps
        if (i == 0) begin : g_first
            assign up_src[i] = '0;
        end else begin : g_up
            assign up_src[i] = store_reg[i-1];
        end
        if (i == BUFFER_DEPTH - 1) begin : g_last
            assign down_src[i] = '0;
        end else begin : g_down
            assign down_src[i] = store_reg[i+1];
        end
    end

    assign limit     = (char_limit > DEPTH_L) ? DEPTH_L : char_limit;
    assign ch        = sle_pkg::key_to_ascii(item.scancode);
    assign count_inc = {1'b0, count_reg} + 1'b1;

    always_comb
    begin
        store_next   = store_reg;
        len_next     = len_reg;
        cur_next     = cur_reg;
        count_next   = count_reg;
        vis_next     = vis_reg;
        release_next = 1'b0;
        if (step) begin
            if (item.command == sle_pkg::CMD_TICK) begin
                if (item.focused) begin
                    if (count_inc >= {1'b0, blink_period}) begin
                        vis_next   = !vis_reg;
                        count_next = '0;
                    end else begin
                        count_next = count_inc[sle_pkg::PERIOD_W-1:0];
                    end
                end else begin
                    vis_next   = 1'b0;
                    count_next = '0;
                end
            end else if (item.focused) begin
                case (item.scancode)
                    sle_pkg::SC_ENTER:
                    begin
                        release_next = 1'b1;
                    end
                    sle_pkg::SC_LEFT:
                    begin
                        if (cur_reg != '0) begin
                            cur_next   = cur_reg - 1'b1;
                            vis_next   = 1'b1;
                            count_next = '0;
                        end
                    end
                    sle_pkg::SC_RIGHT:
                    begin
                        if (cur_reg < len_reg) begin
                            cur_next   = cur_reg + 1'b1;
                            vis_next   = 1'b1;
                            count_next = '0;
                        end
                    end
                    sle_pkg::SC_BACKSPACE:
                    begin
                        if (cur_reg != '0) begin
                            // pull the tail down over the deleted character
                            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                                if (sle_pkg::LEN_W'(i + 1) >= cur_reg) begin
                                    store_next[i] = down_src[i];
                                end
                            end
                            len_next   = len_reg - 1'b1;
                            cur_next   = cur_reg - 1'b1;
                            vis_next   = 1'b1;
                            count_next = '0;
                        end
                    end
                    default:
                    begin
                        if (ch != '0 && len_reg < limit) begin
                            // push the tail up and drop the new character in
                            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                                if (sle_pkg::LEN_W'(i) > cur_reg) begin
                                    store_next[i] = up_src[i];
                                end else if (sle_pkg::LEN_W'(i) == cur_reg) begin
                                    store_next[i] = ch;
                                end
                            end
                            len_next   = len_reg + 1'b1;
                            cur_next   = cur_reg + 1'b1;
                            vis_next   = 1'b1;
                            count_next = '0;
                        end
                    end
                endcase
            end
        end
    end

    for (genvar i = 0; i < sle_pkg::TEXT_CHARS; i++) begin : g_pack
        if (i < BUFFER_DEPTH) begin : g_char
            assign text_all[8*i +: 8] = {1'b0, store_next[i]};
        end else begin : g_none
            assign text_all[8*i +: 8] = 8'h00;
        end
    end

    always_comb
    begin
        result.text_low        = text_all[63:0];
        result.text_high       = text_all[127:64];
        result.text_length     = len_next;
        result.cursor_position = cur_next;
        result.cursor_shown    = vis_next;
        result.release_focus   = release_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                store_reg[i] <= '0;
            end
            len_reg   <= '0;
            cur_reg   <= '0;
            count_reg <= '0;
            vis_reg   <= 1'b0;
        end else begin
            store_reg <= store_next;
            len_reg   <= len_next;
            cur_reg   <= cur_next;
            count_reg <= count_next;
            vis_reg   <= vis_next;
        end
    end

    a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= len_reg)
        else $error("cursor beyond end of line");

    a_length_fits: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= DEPTH_L)
        else $error("line length exceeds store depth");

    a_backspace_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.command == sle_pkg::CMD_KEY && item.focused
         && item.scancode == sle_pkg::SC_BACKSPACE && cur_reg != '0)
        |=> (len_reg == $past(len_reg) - 1'b1) && (cur_reg == $past(cur_reg) - 1'b1))
        else $error("backspace did not shrink line");

    a_blink_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (len_next != len_reg || cur_next != cur_reg))
        |=> vis_reg && count_reg == '0)
        else $error("edit did not restart blink");

    for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_tail_chk
        a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
            (sle_pkg::LEN_W'(i) >= len_reg) |-> store_reg[i] == '0)
            else $error("store position past line end not zero");
    end

endmodule

// ===== sv/scancode_line_editor.sv =====
// Single-line text editor fed by keyboard set-1 make codes and timer ticks.
//
// Input channel (in_valid / in_stall): one transaction carries command (0 key
// press, 1 tick), scancode and focused. Output channel (out_valid / out_stall):
// every input transaction yields exactly one result transaction holding the
// whole line (text_low / text_high, ASCII, eight bits per character), its
// length, cursor position, cursor visibility and the Enter release request.
// Configuration: cfg_write with cfg_index 0 sets the character limit, 1 sets
// blink_period; write only while the block is idle.
//
// Path: the edge that accepts a transaction loads the input register; when the
// result register is free, the edit result loads it and raises out_valid.
// Throughput: one transaction per cycle while out_stall is low; the single-pass
// edit logic between input register and result register sets that rate.
// Reset: text cleared, length and cursor zero, cursor hidden, blink count
// zero, character limit 16 and blink_period 72; no valid output after reset.
// Stall: while out_stall holds a result, the input register keeps one more
// transaction and in_stall rises only when both stages are full.
module scancode_line_editor #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               command,
    input  logic [sle_pkg::SCAN_W-1:0]         scancode,
    input  logic                               focused,
    // configuration port
    input  logic                               cfg_write,
    input  logic [sle_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sle_pkg::CFG_DATA_W-1:0]     cfg_data,
    // output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [63:0]                        text_low,
    output logic [63:0]                        text_high,
    output logic [sle_pkg::LEN_W-1:0]          text_length,
    output logic [sle_pkg::LEN_W-1:0]          cursor_position,
    output logic                               cursor_shown,
    output logic                               release_focus
);

    logic                          in_valid_reg, in_valid_next;
    sle_pkg::sle_item_t            item_reg;
    logic                          out_valid_reg, out_valid_next;
    sle_pkg::sle_result_t          result_reg;
    sle_pkg::sle_result_t          result;
    logic [sle_pkg::LEN_W-1:0]     char_limit_reg;
    logic [sle_pkg::PERIOD_W-1:0]  blink_period_reg;
    logic                          out_ready;
    logic                          advance;
    logic                          accept;

    // Result register free when empty or being drained this cycle
    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_ready;
    assign in_stall  = in_valid_reg && !out_ready;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Edit state and the per-item update live here
    sle_edit #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_edit (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (item_reg),
        .char_limit   (char_limit_reg),
        .blink_period (blink_period_reg),
        .result       (result)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers; unknown indexes drop silently
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            char_limit_reg   <= sle_pkg::CHAR_LIMIT_RESET;
            blink_period_reg <= sle_pkg::BLINK_PERIOD_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                sle_pkg::CFG_CHAR_LIMIT:
                begin
                    char_limit_reg <= cfg_data[sle_pkg::LEN_W-1:0];
                end
                sle_pkg::CFG_BLINK_PERIOD:
                begin
                    blink_period_reg <= cfg_data[sle_pkg::PERIOD_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers: load input on accept, hold result until taken
    always_ff @(posedge clk)
    begin
        if (accept) begin
            item_reg.command  <= command;
            item_reg.scancode <= scancode;
            item_reg.focused  <= focused;
        end
        if (advance) begin
            result_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign text_low        = result_reg.text_low;
    assign text_high       = result_reg.text_high;
    assign text_length     = result_reg.text_length;
    assign cursor_position = result_reg.cursor_position;
    assign cursor_shown    = result_reg.cursor_shown;
    assign release_focus   = result_reg.release_focus;

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item did not reach result register");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending item lost from input register");

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes that map to nothing; writes there must be ignored
    localparam logic [sle_pkg::CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [sle_pkg::CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

    // Printable make codes used by the directed tests
    localparam logic [sle_pkg::SCAN_W-1:0] SC_A      = 8'h1E;
    localparam logic [sle_pkg::SCAN_W-1:0] SC_Q      = 8'h10;
    localparam logic [sle_pkg::SCAN_W-1:0] SC_M      = 8'h32;
    localparam logic [sle_pkg::SCAN_W-1:0] SC_1      = 8'h02;
    localparam logic [sle_pkg::SCAN_W-1:0] SC_MINUS  = 8'h0C;
    localparam logic [sle_pkg::SCAN_W-1:0] SC_COMMA  = 8'h33;
    localparam logic [sle_pkg::SCAN_W-1:0] SC_PERIOD = 8'h34;
    localparam logic [sle_pkg::SCAN_W-1:0] SC_SPACE  = 8'h39;
    // Break code of A and codes with no meaning
    localparam logic [sle_pkg::SCAN_W-1:0] SC_A_BREAK = 8'h9E;
    localparam logic [sle_pkg::SCAN_W-1:0] SC_NONE    = 8'h00;
    localparam logic [sle_pkg::SCAN_W-1:0] SC_UNMAPPED = 8'h3F;
    localparam logic [sle_pkg::SCAN_W-1:0] SC_TOP     = 8'hFF;

    // Cycles without any transaction on either channel before the run is abandoned
    localparam int QUIET_LIMIT = 2000;
    localparam int LINE_DEPTH  = 16;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic                           command;
    logic [sle_pkg::SCAN_W-1:0]     scancode;
    logic                           focused;
    logic                           cfg_write;
    logic [sle_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sle_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           out_valid;
    logic                           out_stall;
    logic [63:0]                    text_low;
    logic [63:0]                    text_high;
    logic [sle_pkg::LEN_W-1:0]      text_length;
    logic [sle_pkg::LEN_W-1:0]      cursor_position;
    logic                           cursor_shown;
    logic                           release_focus;

    scancode_line_editor DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .scancode        (scancode),
        .focused         (focused),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .text_low        (text_low),
        .text_high       (text_high),
        .text_length     (text_length),
        .cursor_position (cursor_position),
        .cursor_shown    (cursor_shown),
        .release_focus   (release_focus)
    );

    // Line snapshots predicted for accepted transactions, oldest first
    sle_pkg::sle_result_t expected_snapshots[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;

    // Traffic shape: percent of cycles the sender idles / the receiver stalls
    int send_gap_pct = 0;
    int stall_pct = 0;

    // Shadow copy of the editor: line contents, caret, blink and registers
    logic [sle_pkg::CHAR_W-1:0] line_chars[LINE_DEPTH];
    int                char_count = 0;
    int                caret = 0;
    int                blink_ticks = 0;
    logic              caret_on = 1'b0;
    int                len_cap = 16;
    int                blink_limit = 72;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver: stall at random in the ratio of the current phase
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // Abandon the run when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[scancode_line_editor] ERROR");
            $finish;
        end
    end

    // Map a set-1 make code to its upper-case ASCII character, zero if not printable
    function automatic logic [sle_pkg::CHAR_W-1:0] char_for_code(
        input logic [sle_pkg::SCAN_W-1:0] code);
        string digit_row = "1234567890-";
        string top_row   = "QWERTYUIOP";
        string home_row  = "ASDFGHJKL";
        string low_row   = "ZXCVBNM,.";
        if (code >= 8'h02 && code <= 8'h0C)
            return sle_pkg::CHAR_W'(digit_row[code - 8'h02]);
        if (code >= 8'h10 && code <= 8'h19)
            return sle_pkg::CHAR_W'(top_row[code - 8'h10]);
        if (code >= 8'h1E && code <= 8'h26)
            return sle_pkg::CHAR_W'(home_row[code - 8'h1E]);
        if (code >= 8'h2C && code <= 8'h34)
            return sle_pkg::CHAR_W'(low_row[code - 8'h2C]);
        if (code == SC_SPACE)
            return 7'h20;
        return '0;
    endfunction

    // Apply one transaction to the shadow editor and return the line snapshot it yields
    function automatic sle_pkg::sle_result_t edit_line(input logic cmd,
                                                       input logic [sle_pkg::SCAN_W-1:0] code,
                                                       input logic foc);
        sle_pkg::sle_result_t       snap;
        logic [sle_pkg::CHAR_W-1:0] ch;
        int                         cap;
        int                         k;
        snap = '0;
        if (cmd == sle_pkg::CMD_TICK)
        begin
            if (foc)
            begin
                // a period of zero acts as one; a count past a lowered period toggles now
                if (blink_ticks + 1 >= blink_limit)
                begin
                    caret_on = !caret_on;
                    blink_ticks = 0;
                end
                else
                    blink_ticks = blink_ticks + 1;
            end
            else
            begin
                caret_on = 1'b0;
                blink_ticks = 0;
            end
        end
        else if (foc)
        begin
            if (code == sle_pkg::SC_ENTER)
                snap.release_focus = 1'b1;
            else if (code == sle_pkg::SC_LEFT)
            begin
                if (caret > 0)
                begin
                    caret--;
                    caret_on = 1'b1;
                    blink_ticks = 0;
                end
            end
            else if (code == sle_pkg::SC_RIGHT)
            begin
                if (caret < char_count)
                begin
                    caret++;
                    caret_on = 1'b1;
                    blink_ticks = 0;
                end
            end
            else if (code == sle_pkg::SC_BACKSPACE)
            begin
                if (caret > 0)
                begin
                    for (k = caret - 1; k + 1 < char_count; k++)
                        line_chars[k] = line_chars[k + 1];
                    char_count--;
                    line_chars[char_count] = '0;
                    caret--;
                    caret_on = 1'b1;
                    blink_ticks = 0;
                end
            end
            else
            begin
                ch = char_for_code(code);
                cap = (len_cap > LINE_DEPTH) ? LINE_DEPTH : len_cap;
                if (ch != '0 && char_count < cap)
                begin
                    for (k = char_count; k > caret; k--)
                        line_chars[k] = line_chars[k - 1];
                    line_chars[caret] = ch;
                    char_count++;
                    caret++;
                    caret_on = 1'b1;
                    blink_ticks = 0;
                end
            end
        end
        for (k = 0; k < 8; k++)
        begin
            snap.text_low[8*k +: 8]  = {1'b0, line_chars[k]};
            snap.text_high[8*k +: 8] = {1'b0, line_chars[k + 8]};
        end
        snap.text_length     = sle_pkg::LEN_W'(char_count);
        snap.cursor_position = sle_pkg::LEN_W'(caret);
        snap.cursor_shown    = caret_on;
        return snap;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s expected %h got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Check every result transaction against the oldest predicted snapshot
    always @(posedge clk)
    begin
        sle_pkg::sle_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (expected_snapshots.size() == 0)
            begin
                $error("result transaction with no input waiting for it");
                mismatch_count++;
            end
            else
            begin
                want = expected_snapshots.pop_front();
                compare_field("text_low", want.text_low, text_low);
                compare_field("text_high", want.text_high, text_high);
                compare_field("text_length", 64'(want.text_length), 64'(text_length));
                compare_field("cursor_position", 64'(want.cursor_position),
                              64'(cursor_position));
                compare_field("cursor_shown", 64'(want.cursor_shown), 64'(cursor_shown));
                compare_field("release_focus", 64'(want.release_focus), 64'(release_focus));
            end
        end
    end

    // Offer one transaction, idling first as the phase asks; hold it until taken.
    // Valid stays high on return: the caller sends again or lowers it in the same step.
    task automatic send_item(input logic cmd, input logic [sle_pkg::SCAN_W-1:0] code,
                             input logic foc);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
        begin
            // drop valid and scramble the idle payload
            in_valid <= 1'b0;
            command  <= 1'($urandom);
            scancode <= sle_pkg::SCAN_W'($urandom);
            focused  <= 1'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        scancode <= code;
        focused  <= foc;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        expected_snapshots.push_back(edit_line(cmd, code, foc));
    endtask

    // Hold off the sender until every predicted snapshot has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_snapshots.size() != 0)
            @(posedge clk);
    endtask

    // Write one register; call only while the block is idle
    task automatic write_reg(input logic [sle_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sle_pkg::CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == sle_pkg::CFG_CHAR_LIMIT)
            len_cap = int'(val[sle_pkg::LEN_W-1:0]);
        else if (idx == sle_pkg::CFG_BLINK_PERIOD)
            blink_limit = int'(val);
        @(posedge clk);
    endtask

    task automatic set_traffic(input int gap, input int stall);
        send_gap_pct = gap;
        stall_pct = stall;
    endtask

    // Reset snapshot, cursor at both ends, typing, mid-line edits, Enter and dead codes
    task automatic test_edit_keys();
        set_traffic(0, 0);
        send_item(sle_pkg::CMD_TICK, SC_TOP, 1'b1);
        send_item(sle_pkg::CMD_KEY, SC_A, 1'b0);
        send_item(sle_pkg::CMD_KEY, sle_pkg::SC_LEFT, 1'b1);
        send_item(sle_pkg::CMD_KEY, sle_pkg::SC_BACKSPACE, 1'b1);
        send_item(sle_pkg::CMD_KEY, sle_pkg::SC_RIGHT, 1'b1);
        send_item(sle_pkg::CMD_KEY, SC_1, 1'b1);
        send_item(sle_pkg::CMD_KEY, SC_SPACE, 1'b1);
        send_item(sle_pkg::CMD_KEY, SC_PERIOD, 1'b1);
        send_item(sle_pkg::CMD_KEY, SC_COMMA, 1'b1);
        send_item(sle_pkg::CMD_KEY, SC_MINUS, 1'b1);
        send_item(sle_pkg::CMD_KEY, SC_M, 1'b1);
        send_item(sle_pkg::CMD_KEY, sle_pkg::SC_LEFT, 1'b1);
        send_item(sle_pkg::CMD_KEY, sle_pkg::SC_LEFT, 1'b1);
        send_item(sle_pkg::CMD_KEY, SC_Q, 1'b1);
        send_item(sle_pkg::CMD_KEY, sle_pkg::SC_BACKSPACE, 1'b1);
        send_item(sle_pkg::CMD_KEY, sle_pkg::SC_RIGHT, 1'b1);
        send_item(sle_pkg::CMD_KEY, sle_pkg::SC_RIGHT, 1'b1);
        send_item(sle_pkg::CMD_KEY, sle_pkg::SC_ENTER, 1'b1);
        send_item(sle_pkg::CMD_KEY, sle_pkg::SC_ENTER, 1'b0);
        send_item(sle_pkg::CMD_KEY, SC_TOP, 1'b1);
        send_item(sle_pkg::CMD_KEY, SC_A_BREAK, 1'b1);
        send_item(sle_pkg::CMD_KEY, SC_NONE, 1'b1);
        send_item(sle_pkg::CMD_KEY, SC_UNMAPPED, 1'b1);
        send_item(sle_pkg::CMD_TICK, SC_NONE, 1'b0);
        wait_for_results();
    endtask

    // Limit below the current length, a zero limit, a limit past the depth, dead indexes
    task automatic test_length_limit();
        write_reg(sle_pkg::CFG_CHAR_LIMIT, 8'd2);
        send_item(sle_pkg::CMD_KEY, SC_A, 1'b1);
        wait_for_results();
        write_reg(sle_pkg::CFG_CHAR_LIMIT, 8'd0);
        send_item(sle_pkg::CMD_KEY, SC_A, 1'b1);
        wait_for_results();
        // upper bits fall away: the limit becomes 31, clipped to the depth
        write_reg(sle_pkg::CFG_CHAR_LIMIT, 8'hFF);
        write_reg(CFG_UNUSED_2, 8'h55);
        write_reg(CFG_UNUSED_3, 8'hAA);
        send_item(sle_pkg::CMD_KEY, SC_A, 1'b1);
        wait_for_results();
    endtask

    // Zero period toggles on every tick; lowering the period below the count toggles next
    task automatic test_blink_timing();
        int n;
        write_reg(sle_pkg::CFG_BLINK_PERIOD, 8'd0);
        for (n = 0; n < 3; n++)
            send_item(sle_pkg::CMD_TICK, SC_NONE, 1'b1);
        wait_for_results();
        write_reg(sle_pkg::CFG_BLINK_PERIOD, sle_pkg::BLINK_PERIOD_RESET);
        for (n = 0; n < 6; n++)
            send_item(sle_pkg::CMD_TICK, SC_NONE, 1'b1);
        wait_for_results();
        write_reg(sle_pkg::CFG_BLINK_PERIOD, 8'd4);
        send_item(sle_pkg::CMD_TICK, SC_NONE, 1'b1);
        wait_for_results();
    endtask

    // Mostly focused editing with random keys, some ticks, some unfocused noise
    task automatic send_random_edit();
        int                         pick;
        int                         sel;
        logic [sle_pkg::SCAN_W-1:0] code;
        pick = $urandom_range(99);
        if (pick < 62)
        begin
            sel = $urandom_range(99);
            if (sel < 50)
            begin
                do
                    code = sle_pkg::SCAN_W'($urandom_range(8'h39, 8'h02));
                while (char_for_code(code) == '0);
            end
            else if (sel < 60)
                code = sle_pkg::SC_LEFT;
            else if (sel < 70)
                code = sle_pkg::SC_RIGHT;
            else if (sel < 88)
                code = sle_pkg::SC_BACKSPACE;
            else if (sel < 92)
                code = sle_pkg::SC_ENTER;
            else
                code = sle_pkg::SCAN_W'($urandom);
            send_item(sle_pkg::CMD_KEY, code, 1'b1);
        end
        else if (pick < 88)
            send_item(sle_pkg::CMD_TICK, sle_pkg::SCAN_W'($urandom), 1'b1);
        else if (pick < 95)
            send_item(sle_pkg::CMD_KEY, sle_pkg::SCAN_W'($urandom), 1'b0);
        else
            send_item(sle_pkg::CMD_TICK, sle_pkg::SCAN_W'($urandom), 1'b0);
    endtask

    // Rounds of random editing, each under its own register setting and traffic phase
    task automatic test_random_traffic();
        int limits[8]  = '{16, 31, 0, 5, 16, 1, 12, 20};
        int periods[8] = '{72, 1, 255, 0, 3, 2, 10, 6};
        int round;
        int n;
        for (round = 0; round < 8; round++)
        begin
            write_reg(sle_pkg::CFG_CHAR_LIMIT, {3'($urandom), 5'(limits[round])});
            write_reg(sle_pkg::CFG_BLINK_PERIOD, 8'(periods[round]));
            write_reg(round[0] ? CFG_UNUSED_3 : CFG_UNUSED_2, 8'($urandom));
            case (round % 4)
                0: set_traffic(0, 0);
                1: set_traffic(65, 0);
                2: set_traffic(0, 65);
                default: set_traffic(28, 28);
            endcase
            for (n = 0; n < 240; n++)
                send_random_edit();
            wait_for_results();
        end
    endtask

    initial
    begin
        int k;
        for (k = 0; k < LINE_DEPTH; k++)
            line_chars[k] = '0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        command   <= sle_pkg::CMD_KEY;
        scancode  <= '0;
        focused   <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= sle_pkg::CFG_CHAR_LIMIT;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edit_keys();
        test_length_limit();
        test_blink_timing();
        test_random_traffic();

        // everything is back; give a stray late result time to show up
        wait_for_results();
        repeat (6) @(posedge clk);
        if (mismatch_count == 0)
            $display("[scancode_line_editor] OK");
        else
            $display("[scancode_line_editor] ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/sle_pkg.sv
sv/sle_edit.sv
sv/scancode_line_editor.sv
sim/tb.sv
